// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fade and volume stage.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AOFV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AOFV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AOFV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AOFV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/aofv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aofv_pkg
// Types and constants of the audio output fade and volume stage.
// ---------------------------------------------------------------------------
package aofv_pkg;

    localparam int RawW    = 32;
    localparam int SampW   = 16;
    localparam int ScopeW  = 8;
    localparam int FadeW   = 4;
    localparam int TimeW   = 12;
    localparam int RateW   = 16;
    localparam int VolW    = 8;
    localparam int SpeedW  = 8;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 3;
    localparam int GainW   = VolW + FadeW;
    localparam int AccW    = SampW + 2;
    localparam int StepW   = 4;
    localparam int DivSteps = 4;
    localparam int RemW    = RateW + FadeW;

    localparam logic [TimeW-1:0]  PlayCap      = 12'd3600;
    localparam logic [FadeW-1:0]  FadeFull     = 4'hF;
    localparam logic [FadeW-1:0]  FadeOff      = 4'h0;
    localparam logic [TimeW-1:0]  MinFadeDur   = 12'd4;
    localparam logic [SampW-1:0]  SampMax      = 16'h7FFF;
    localparam logic [SampW-1:0]  SampMin      = 16'h8000;
    localparam logic [RateW-1:0]  RateReset    = 16'd44100;
    localparam logic [VolW-1:0]   VolReset     = 8'd255;
    localparam logic [SpeedW-1:0] SpeedReset   = 8'd1;
    localparam logic [StepW-1:0]  MulLastStep  = 4'd11;
    localparam logic [1:0]        DivLastStep  = 2'd3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SAMPLE_RATE   = 3'd0,
        CFG_MAIN_VOLUME   = 3'd1,
        CFG_PLAY_SPEED    = 3'd2,
        CFG_DURATION      = 3'd3,
        CFG_ADVANCE_EN    = 3'd4,
        CFG_FADE_EN       = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_PREP = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage
`default_nettype wire

// ----- rtl/aofv_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aofv channels
// Valid/ready channels carrying raw input items and result items.
// ---------------------------------------------------------------------------
interface aofv_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [aofv_pkg::RawW-1:0]   raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface aofv_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [aofv_pkg::SampW-1:0]   sample_out;
    logic signed [aofv_pkg::ScopeW-1:0]  scope_level;
    logic [aofv_pkg::FadeW-1:0]          fade_level;
    logic                                time_expired;
    logic [aofv_pkg::TimeW-1:0]          play_seconds;

    modport source (output valid, output sample_out, output scope_level,
                    output fade_level, output time_expired, output play_seconds,
                    input ready);
    modport sink   (input valid, input sample_out, input scope_level,
                    input fade_level, input time_expired, input play_seconds,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/audio_output_fade_volume_stage_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: an emitted item runs through a 4-step quotient loop during a fade ramp,
// then a bit-serial volume multiply, then the output register.
// Throughput: one raw item per cycle when it emits nothing; an emitted item
// holds off new input until the divider loop and the serial multiplier are through and its result is loaded.
// Reset: rst_n, asynchronous, active low; restores register defaults and
// clears all counters and the scope filter.
// ---------------------------------------------------------------------------
// audio_output_fade_volume_stage_top
// Second and play-time counters, speed decimation, fade ramp, saturation,
// volume/fade scaling and one-pole scope filter.
// ---------------------------------------------------------------------------
module audio_output_fade_volume_stage_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [aofv_pkg::CfgIdxW-1:0]          cfg_index,
    input  wire logic [aofv_pkg::CfgW-1:0]             cfg_data,
    aofv_in_if.sink                                    in_ch,
    aofv_out_if.source                                 out_ch
);

    logic [aofv_pkg::RateW-1:0]   sample_rate_reg;
    logic [aofv_pkg::VolW-1:0]    main_volume_reg;
    logic [aofv_pkg::SpeedW-1:0]  playback_speed_reg;
    logic [aofv_pkg::TimeW-1:0]   duration_reg;
    logic                         advance_en_reg;
    logic                         fade_en_reg;

    logic [aofv_pkg::SpeedW-1:0]  speed_count_reg;
    logic [aofv_pkg::RateW-1:0]   second_count_reg;
    logic [aofv_pkg::TimeW-1:0]   play_time_reg;
    logic signed [aofv_pkg::ScopeW-1:0] scope_reg;

    aofv_pkg::state_t             state_reg;
    logic [aofv_pkg::FadeW-1:0]   fade_reg;
    logic                         expired_reg;
    logic signed [aofv_pkg::SampW-1:0] sat_reg;
    logic [aofv_pkg::RemW-1:0]    rem_reg;
    logic [aofv_pkg::RemW-1:0]    dvs_reg;
    logic [aofv_pkg::FadeW-1:0]   quo_reg;
    logic [1:0]                   div_step_reg;

    logic                         out_valid_reg;
    logic signed [aofv_pkg::SampW-1:0]  out_sample_reg;
    logic signed [aofv_pkg::ScopeW-1:0] out_scope_reg;
    logic [aofv_pkg::FadeW-1:0]   out_fade_reg;
    logic                         out_expired_reg;
    logic [aofv_pkg::TimeW-1:0]   out_time_reg;

    logic                         accept;
    logic [aofv_pkg::RateW-1:0]   second_count_next;
    logic [aofv_pkg::TimeW-1:0]   play_time_next;
    logic [aofv_pkg::SpeedW-1:0]  speed_inc;
    logic [aofv_pkg::SpeedW-1:0]  speed_eff;
    logic                         emit;
    logic                         limit_on;
    logic                         fading;
    logic                         expired;
    logic                         final_sec;
    logic                         need_div;
    logic [aofv_pkg::FadeW-1:0]   fade_direct;
    logic signed [aofv_pkg::SampW-1:0] sat_next;
    logic                         div_take;
    logic                         out_load;
    logic signed [aofv_pkg::SampW-1:0]  prod_hi;
    logic signed [aofv_pkg::ScopeW-1:0] hi_byte;
    logic signed [aofv_pkg::ScopeW:0]   scope_diff;
    logic signed [aofv_pkg::ScopeW:0]   scope_sum;
    aofv_pkg::mul_ctrl_t          mul_ctrl;
    aofv_pkg::mul_stat_t          mul_stat;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == aofv_pkg::S_IDLE);

    always_comb
    begin
        if (second_count_reg < sample_rate_reg)
        begin
            second_count_next = second_count_reg + 1'b1;
            play_time_next    = play_time_reg;
        end
        else
        begin
            second_count_next = '0;
            play_time_next    = (play_time_reg < aofv_pkg::PlayCap) ?
                                play_time_reg + 1'b1 : play_time_reg;
        end
    end

    assign speed_inc = speed_count_reg + 1'b1;
    assign speed_eff = (playback_speed_reg == '0) ? aofv_pkg::SpeedReset : playback_speed_reg;
    assign emit      = (speed_inc >= speed_eff);

    assign limit_on  = advance_en_reg && (duration_reg != '0);
    assign fading    = fade_en_reg && (duration_reg > aofv_pkg::MinFadeDur);
    assign expired   = limit_on && (play_time_next == duration_reg);
    assign final_sec = limit_on && !expired && fading &&
                       ({1'b0, play_time_next} + 1'b1 == {1'b0, duration_reg});
    assign need_div  = final_sec && (second_count_next < sample_rate_reg);

    always_comb
    begin
        if (expired)
        begin
            fade_direct = fading ? aofv_pkg::FadeOff : aofv_pkg::FadeFull;
        end
        else if (final_sec)
        begin
            fade_direct = aofv_pkg::FadeOff;
        end
        else
        begin
            fade_direct = aofv_pkg::FadeFull;
        end
    end

    always_comb
    begin
        if (in_ch.raw_sample[aofv_pkg::RawW-1:aofv_pkg::SampW-1] == '0 ||
            in_ch.raw_sample[aofv_pkg::RawW-1:aofv_pkg::SampW-1] == '1)
        begin
            sat_next = in_ch.raw_sample[aofv_pkg::SampW-1:0];
        end
        else if (in_ch.raw_sample[aofv_pkg::RawW-1])
        begin
            sat_next = aofv_pkg::SampMin;
        end
        else
        begin
            sat_next = aofv_pkg::SampMax;
        end
    end

    // restoring step: quotient of 15 * second_count / sample_rate, below 15
    assign div_take = (rem_reg >= dvs_reg);
    assign out_load = (state_reg == aofv_pkg::S_DONE) && (!out_valid_reg || out_ch.ready);
    assign mul_ctrl.start = (state_reg == aofv_pkg::S_PREP);

    assign hi_byte    = prod_hi[aofv_pkg::SampW-1:aofv_pkg::SampW-aofv_pkg::ScopeW];
    assign scope_diff = {hi_byte[aofv_pkg::ScopeW-1], hi_byte} -
                        {scope_reg[aofv_pkg::ScopeW-1], scope_reg};
    assign scope_sum  = $signed({scope_reg[aofv_pkg::ScopeW-1], scope_reg}) +
                        (scope_diff >>> 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg    <= aofv_pkg::RateReset;
            main_volume_reg    <= aofv_pkg::VolReset;
            playback_speed_reg <= aofv_pkg::SpeedReset;
            duration_reg       <= '0;
            advance_en_reg     <= 1'b0;
            fade_en_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (aofv_pkg::cfg_idx_t'(cfg_index))
                aofv_pkg::CFG_SAMPLE_RATE: sample_rate_reg    <= cfg_data[aofv_pkg::RateW-1:0];
                aofv_pkg::CFG_MAIN_VOLUME: main_volume_reg    <= cfg_data[aofv_pkg::VolW-1:0];
                aofv_pkg::CFG_PLAY_SPEED:  playback_speed_reg <= cfg_data[aofv_pkg::SpeedW-1:0];
                aofv_pkg::CFG_DURATION:    duration_reg       <= cfg_data[aofv_pkg::TimeW-1:0];
                aofv_pkg::CFG_ADVANCE_EN:  advance_en_reg     <= cfg_data[0];
                aofv_pkg::CFG_FADE_EN:     fade_en_reg        <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= aofv_pkg::S_IDLE;
            speed_count_reg  <= '0;
            second_count_reg <= '0;
            play_time_reg    <= '0;
            scope_reg        <= '0;
            out_valid_reg    <= 1'b0;
            div_step_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                aofv_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        second_count_reg <= second_count_next;
                        play_time_reg    <= play_time_next;
                        speed_count_reg  <= emit ? '0 : speed_inc;
                        if (emit)
                        begin
                            div_step_reg <= '0;
                            state_reg    <= need_div ? aofv_pkg::S_DIV : aofv_pkg::S_PREP;
                        end
                    end
                end
                aofv_pkg::S_DIV:
                begin
                    div_step_reg <= div_step_reg + 1'b1;
                    if (div_step_reg == aofv_pkg::DivLastStep)
                    begin
                        state_reg <= aofv_pkg::S_PREP;
                    end
                end
                aofv_pkg::S_PREP:
                begin
                    state_reg <= aofv_pkg::S_MUL;
                end
                aofv_pkg::S_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        state_reg <= aofv_pkg::S_DONE;
                    end
                end
                aofv_pkg::S_DONE:
                begin
                    if (out_load)
                    begin
                        scope_reg <= scope_sum[aofv_pkg::ScopeW-1:0];
                        state_reg <= aofv_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= aofv_pkg::S_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            sat_reg     <= sat_next;
            expired_reg <= expired;
            fade_reg    <= fade_direct;
            rem_reg     <= {second_count_next, {aofv_pkg::FadeW{1'b0}}} -
                           aofv_pkg::RemW'(second_count_next);
            dvs_reg     <= {1'b0, sample_rate_reg, 3'b000};
            quo_reg     <= '0;
        end
        else if (state_reg == aofv_pkg::S_DIV)
        begin
            if (div_take)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[aofv_pkg::FadeW-2:0], div_take};
            if (div_step_reg == aofv_pkg::DivLastStep)
            begin
                fade_reg <= aofv_pkg::FadeFull - {quo_reg[aofv_pkg::FadeW-2:0], div_take};
            end
        end

        if (out_load)
        begin
            out_sample_reg  <= prod_hi;
            out_scope_reg   <= scope_sum[aofv_pkg::ScopeW-1:0];
            out_fade_reg    <= fade_reg;
            out_expired_reg <= expired_reg;
            out_time_reg    <= play_time_reg;
        end
    end

    aofv_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .mcand   (sat_reg),
        .gain    (aofv_pkg::GainW'(main_volume_reg) * aofv_pkg::GainW'(fade_reg)),
        .stat    (mul_stat),
        .prod_hi (prod_hi)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sample_out   = out_sample_reg;
    assign out_ch.scope_level  = out_scope_reg;
    assign out_ch.fade_level   = out_fade_reg;
    assign out_ch.time_expired = out_expired_reg;
    assign out_ch.play_seconds = out_time_reg;

    `include "assert_macros.svh"

    `AOFV_ASSERT_IMP(a_play_time_cap, clk, rst_n, 1'b1, play_time_reg <= aofv_pkg::PlayCap)
    `AOFV_ASSERT_NXT(a_mul_to_done, clk, rst_n,
        state_reg == aofv_pkg::S_MUL && mul_stat.done, state_reg == aofv_pkg::S_DONE)
    `AOFV_ASSERT_IMP(a_mul_busy_state, clk, rst_n, mul_stat.busy, state_reg == aofv_pkg::S_MUL)
    `AOFV_ASSERT_IMP(a_expired_fade, clk, rst_n, out_valid_reg && out_expired_reg,
        out_fade_reg == aofv_pkg::FadeOff || out_fade_reg == aofv_pkg::FadeFull)

endmodule
`default_nettype wire

// ----- rtl/aofv_smul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aofv_smul
// Bit-serial signed by unsigned multiplier, one gain bit per cycle, LSB
// first; returns the product shifted right by the gain width (floor).
// ---------------------------------------------------------------------------
module aofv_smul (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire aofv_pkg::mul_ctrl_t               ctrl,
    input  wire logic signed [aofv_pkg::SampW-1:0] mcand,
    input  wire logic [aofv_pkg::GainW-1:0]        gain,
    output aofv_pkg::mul_stat_t                    stat,
    output logic signed [aofv_pkg::SampW-1:0]      prod_hi
);

    logic                               busy_reg;
    logic [aofv_pkg::StepW-1:0]         step_reg;
    logic signed [aofv_pkg::SampW-1:0]  mcand_reg;
    logic [aofv_pkg::GainW-1:0]         gain_reg;
    logic signed [aofv_pkg::AccW-1:0]   acc_reg;
    logic signed [aofv_pkg::AccW-1:0]   acc_next;
    logic signed [aofv_pkg::AccW-1:0]   addend;
    logic                               last_step;

    assign addend    = gain_reg[0] ? aofv_pkg::AccW'(mcand_reg) : '0;
    assign acc_next  = (acc_reg + addend) >>> 1;
    assign last_step = busy_reg && (step_reg == aofv_pkg::MulLastStep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mcand_reg <= mcand;
            gain_reg  <= gain;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            gain_reg <= gain_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = last_step;
    assign prod_hi   = acc_reg[aofv_pkg::SampW-1:0];

    `include "assert_macros.svh"

    `AOFV_ASSERT_NXT(a_smul_done_idle, clk, rst_n, last_step && !ctrl.start, !busy_reg)
    `AOFV_ASSERT_IMP(a_smul_no_restart, clk, rst_n, ctrl.start, !busy_reg)
    `AOFV_ASSERT_NXT(a_smul_start_busy, clk, rst_n, ctrl.start, busy_reg && step_reg == '0)

endmodule
`default_nettype wire

// ----- tb/sv/audio_output_fade_volume_stage_top_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_output_fade_volume_stage_top_test
// Drives raw samples through the fade and volume stage and checks every
// emitted sample against a cycle-free model of the counters, the fade ramp,
// the expiry flag, the volume scaling and the scope filter, or against the
// stored value for a typed row of the short directed table that opens the
// run. Random phases follow, each with a fresh register setting aimed at
// expiry and the fade ramp. Both handshake sides idle and stall at random.
// ---------------------------------------------------------------------------
module audio_output_fade_volume_stage_top_test;
    import aofv_pkg::*;

    localparam int RandomItems  = 600;
    localparam int DrainCycles  = 40;
    localparam int LongHold     = 400;
    localparam int PhaseItemCap = 80;
    localparam int VolShift     = 12;
    localparam int ScopeShift   = 8;
    localparam int ScopePole    = 2;
    localparam logic [11:0] DurationMax = 12'hFFF;

    typedef struct packed {
        logic signed [SampW-1:0]  sample;
        logic signed [ScopeW-1:0] scope;
        logic [FadeW-1:0]         fade;
        logic                     expired;
        logic [TimeW-1:0]         seconds;
    } audio_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_e;

    typedef struct packed {
        row_kind_e     kind;
        cfg_idx_t      reg_idx;
        logic [31:0]   value;
        logic          typed;
        audio_result_t want;
    } stim_row_t;

    localparam int DirRows = 32;
    localparam stim_row_t DirectedRows [0:DirRows-1] = '{
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_0000, 1'b1,
          '{16'sd0, 8'sd0, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_7FFF, 1'b1,
          '{16'sd30599, 8'sd29, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h7FFF_FFFF, 1'b1,
          '{16'sd30599, 8'sd51, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h8000_0000, 1'b1,
          '{-16'sd30600, 8'sd8, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_7FFF, 1'b1,
          '{-16'sd30600, -8'sd24, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_FFFF, 1'b1,
          '{-16'sd1, -8'sd19, FadeFull, 1'b0, 12'd0}},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_8000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_8000, 1'b0, '0},
        '{ROW_REG,  CFG_PLAY_SPEED,  32'd0,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h1234_5678, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hA5A5_A5A5, 1'b0, '0},
        '{ROW_REG,  CFG_PLAY_SPEED,  32'd3,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_1000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_F000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_4000, 1'b0, '0},
        '{ROW_REG,  CFG_PLAY_SPEED,  32'd1,         1'b0, '0},
        '{ROW_REG,  CFG_MAIN_VOLUME, 32'd0,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_7FFF, 1'b0, '0},
        '{ROW_REG,  CFG_MAIN_VOLUME, 32'd1,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h8000_0000, 1'b0, '0},
        '{ROW_REG,  CFG_MAIN_VOLUME, 32'd255,       1'b0, '0},
        '{ROW_REG,  CFG_SAMPLE_RATE, 32'd0,         1'b0, '0},
        '{ROW_REG,  CFG_DURATION,    32'd2,         1'b0, '0},
        '{ROW_REG,  CFG_ADVANCE_EN,  32'd1,         1'b0, '0},
        '{ROW_REG,  CFG_FADE_EN,     32'd1,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_2000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_E000, 1'b0, '0},
        '{ROW_REG,  CFG_DURATION,    32'd5,         1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_7000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'hFFFF_9000, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_7FFF, 1'b0, '0},
        '{ROW_ITEM, CFG_SAMPLE_RATE, 32'h0000_0100, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;

    aofv_in_if  in_bus ();
    aofv_out_if out_bus ();

    audio_output_fade_volume_stage_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    logic [RateW-1:0]  rate_reg     = RateReset;
    logic [VolW-1:0]   volume_reg   = VolReset;
    logic [SpeedW-1:0] speed_reg    = SpeedReset;
    logic [TimeW-1:0]  duration_reg = '0;
    logic              advance_reg  = 1'b0;
    logic              fade_en_reg  = 1'b0;

    logic [SpeedW-1:0]        speed_cnt  = '0;
    logic [RateW-1:0]         second_cnt = '0;
    logic [TimeW-1:0]         play_time  = '0;
    logic signed [ScopeW-1:0] scope_acc  = '0;

    audio_result_t pending_samples [$];
    int  error_count    = 0;
    int  accepted_items = 0;
    bit  calm           = 1'b0;
    bit  long_hold_done = 1'b0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] next_raw();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_7FFF;
                    3:       return 32'hFFFF_8000;
                    4:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4, 5: return 32'($urandom_range(0, 65535)) - 32'd32768;
            default:       return $urandom();
        endcase
    endfunction

    // advance the counters by one raw sample; returns 1 when a sample is emitted
    function automatic bit advance_stage(input logic signed [RawW-1:0] raw,
                                         output audio_result_t res);
        int unsigned   speed_eff;
        int unsigned   quot;
        logic [FadeW-1:0] fade;
        logic          expired;
        bit            fading;
        longint        sat;
        longint        scaled;
        longint        hi;
        longint        diff;
        res       = '0;
        fade      = FadeFull;
        expired   = 1'b0;
        speed_eff = (speed_reg == 0) ? 1 : speed_reg;
        if (second_cnt < rate_reg)
            second_cnt = second_cnt + 1'b1;
        else
        begin
            second_cnt = '0;
            if (play_time < PlayCap)
                play_time = play_time + 1'b1;
        end
        speed_cnt = speed_cnt + 1'b1;
        if (speed_cnt < speed_eff)
            return 1'b0;
        speed_cnt = '0;
        if (advance_reg && duration_reg != 0)
        begin
            fading = fade_en_reg && (duration_reg > MinFadeDur);
            if (play_time == duration_reg)
            begin
                expired = 1'b1;
                fade    = fading ? FadeOff : FadeFull;
            end
            else if (fading && int'(play_time) + 1 == int'(duration_reg))
            begin
                if (rate_reg == 0)
                    fade = FadeOff;
                else
                begin
                    quot = (int'(FadeFull) * int'(second_cnt)) / int'(rate_reg);
                    fade = (quot >= FadeFull) ? FadeOff : FadeFull - 4'(quot);
                end
            end
        end
        sat = raw;
        if (sat > longint'($signed(SampMax)))
            sat = longint'($signed(SampMax));
        if (sat < longint'($signed(SampMin)))
            sat = longint'($signed(SampMin));
        scaled    = (sat * longint'(volume_reg) * longint'(fade)) >>> VolShift;
        hi        = scaled >>> ScopeShift;
        diff      = (hi - longint'(scope_acc)) >>> ScopePole;
        scope_acc = ScopeW'(longint'(scope_acc) + diff);
        res.sample  = scaled[SampW-1:0];
        res.scope   = scope_acc;
        res.fade    = fade;
        res.expired = expired;
        res.seconds = play_time;
        return 1'b1;
    endfunction

    task automatic note_error(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic push_raw(input logic [31:0] raw, input logic typed,
                            input audio_result_t typed_want);
        int            gap;
        audio_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.raw_sample <= raw;
        do
            @(posedge clk);
        while (!in_bus.ready);
        accepted_items++;
        if (advance_stage(raw, res))
            pending_samples.push_back(typed ? typed_want : res);
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SAMPLE_RATE: rate_reg     = data;
            CFG_MAIN_VOLUME: volume_reg   = data[VolW-1:0];
            CFG_PLAY_SPEED:  speed_reg    = data[SpeedW-1:0];
            CFG_DURATION:    duration_reg = data[TimeW-1:0];
            CFG_ADVANCE_EN:  advance_reg  = data[0];
            CFG_FADE_EN:     fade_en_reg  = data[0];
            default: ;
        endcase
    endtask

    task automatic random_phase(input int phase_no, inout int added);
        int rate;
        int dur;
        int lead;
        int n;
        wait_idle();
        case ($urandom_range(0, 9))
            0:       rate = 0;
            1:       rate = 65535;
            2:       rate = $urandom_range(8, 40);
            default: rate = $urandom_range(1, 7);
        endcase
        if (phase_no == 1)
            rate = 65535;
        lead = $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            0:       dur = 0;
            1:       dur = $urandom_range(1, 4);
            2:       dur = $urandom_range(int'(PlayCap) + 1, int'(DurationMax));
            3:       dur = play_time;
            4:       dur = $urandom_range(0, int'(DurationMax));
            default: dur = int'(play_time) + lead;
        endcase
        if (dur > int'(DurationMax))
            dur = DurationMax;
        write_reg(CFG_SAMPLE_RATE, CfgW'(rate));
        case ($urandom_range(0, 9))
            0:       write_reg(CFG_MAIN_VOLUME, 16'd0);
            1:       write_reg(CFG_MAIN_VOLUME, 16'd255);
            default: write_reg(CFG_MAIN_VOLUME, CfgW'($urandom_range(0, 255)));
        endcase
        case ($urandom_range(0, 9))
            0:       write_reg(CFG_PLAY_SPEED, 16'd0);
            1:       write_reg(CFG_PLAY_SPEED, 16'd255);
            2, 3:    write_reg(CFG_PLAY_SPEED, CfgW'($urandom_range(2, 4)));
            default: write_reg(CFG_PLAY_SPEED, 16'd1);
        endcase
        write_reg(CFG_DURATION, CfgW'(dur));
        write_reg(CFG_ADVANCE_EN, CfgW'($urandom_range(0, 7) != 0));
        write_reg(CFG_FADE_EN, CfgW'($urandom_range(0, 5) != 0));
        calm = ($urandom_range(0, 3) == 0);
        if (rate <= 40)
            n = (rate + 1) * (lead + 1) + $urandom_range(0, 8);
        else
            n = $urandom_range(10, 40);
        if (n > PhaseItemCap)
            n = PhaseItemCap;
        repeat (n) push_raw(next_raw(), 1'b0, '0);
        added += n;
    endtask

    always @(posedge clk)
    begin
        audio_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (pending_samples.size() == 0)
                note_error("unexpected sample_out", out_bus.sample_out, 0);
            else
            begin
                want = pending_samples.pop_front();
                if (out_bus.sample_out !== want.sample)
                    note_error("sample_out", out_bus.sample_out, want.sample);
                if (out_bus.scope_level !== want.scope)
                    note_error("scope_level", out_bus.scope_level, want.scope);
                if (out_bus.fade_level !== want.fade)
                    note_error("fade_level", out_bus.fade_level, want.fade);
                if (out_bus.time_expired !== want.expired)
                    note_error("time_expired", out_bus.time_expired, want.expired);
                if (out_bus.play_seconds !== want.seconds)
                    note_error("play_seconds", out_bus.play_seconds, want.seconds);
            end
        end
    end

    initial
    begin
        int stall;
        out_bus.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && accepted_items >= 2)
            begin
                long_hold_done = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_bus.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int        added;
        int        phase_no;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_SAMPLE_RATE;
        cfg_data          = '0;
        in_bus.valid      = 1'b0;
        in_bus.raw_sample = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DirRows; i++)
        begin
            row = DirectedRows[i];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_idx, row.value[CfgW-1:0]);
            end
            else
                push_raw(row.value, row.typed, row.want);
        end
        added    = 0;
        phase_no = 0;
        while (added < RandomItems)
        begin
            random_phase(phase_no, added);
            phase_no++;
        end
        wait_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/aofv_pkg.sv
rtl/aofv_channels.sv
rtl/aofv_smul.sv
rtl/audio_output_fade_volume_stage_top.sv
tb/sv/audio_output_fade_volume_stage_top_test.sv
